// ----- rtl/fbot_pkg.sv -----
`default_nettype none

package fbot_pkg;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 8;
   localparam int TIME_W   = 64;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_FRAME_DONE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE    = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE    = 3'd2;
   localparam logic [OP_W-1:0] OP_STREAM_ON  = 3'd3;
   localparam logic [OP_W-1:0] OP_STREAM_OFF = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_STREAMING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_READY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNCHANGED     = 3'd4;

   typedef struct packed {
      logic set;
      logic clr;
   } ready_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/fbot_time_ram.sv -----
`default_nettype none

module fbot_time_ram #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [fbot_pkg::TIME_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [fbot_pkg::TIME_W-1:0] rd_data
);

   logic [fbot_pkg::TIME_W-1:0] time_mem_ff [DEPTH];
   logic [fbot_pkg::TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= time_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/fbot_ready_table.sv -----
`default_nettype none

module fbot_ready_table #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fbot_pkg::ready_cmd_type cmd,
   input  wire logic [AW-1:0]           idx,
   output logic                         found,
   output logic      [AW-1:0]           first_idx
);

   logic [DEPTH-1:0] ready_ff;
   logic [DEPTH-1:0] ready_in;

   always_comb begin
      ready_in = ready_ff;
      if (cmd.set) begin
         ready_in[idx] = 1'b1;
      end else if (cmd.clr) begin
         ready_in[idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
      end else begin
         ready_ff <= ready_in;
      end
   end

   // Lowest-index ready buffer wins.
   always_comb begin
      first_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (ready_ff[i]) begin
            first_idx = AW'(i);
         end
      end
   end

   assign found = |ready_ff;

endmodule

`default_nettype wire

// ----- rtl/frame_buffer_ownership_table.sv -----
// Ownership table for NUM_BUFFERS capture frame buffers. Issue a command by
// raising start while busy is low; the command is taken at that clock edge and
// busy stays high for the following cycle, in which the result is presented on
// the rsp_ ports with rsp_strobe high for exactly one cycle. The result is
// registered, and so is the read of the timestamp memory that a dequeue
// reads. Results cannot be held off, so they must be captured in the cycle
// that rsp_strobe marks. Granted slot and time read as zero for every result
// other than a successful dequeue.
`default_nettype none

module frame_buffer_ownership_table #(
   parameter int NUM_BUFFERS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [fbot_pkg::OP_W-1:0]     req_operation,
   input  wire logic [fbot_pkg::SLOT_W-1:0]   req_buffer_slot,
   input  wire logic [fbot_pkg::TIME_W-1:0]   req_capture_time,
   output logic                               rsp_strobe,
   output logic      [fbot_pkg::STATUS_W-1:0] rsp_status,
   output logic      [fbot_pkg::SLOT_W-1:0]   rsp_granted_slot,
   output logic      [fbot_pkg::TIME_W-1:0]   rsp_granted_time
);

   localparam int AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

   logic                          busy_ff;
   logic                          streaming_ff;
   logic                          streaming_in;
   logic [fbot_pkg::STATUS_W-1:0] status_ff;
   logic [fbot_pkg::STATUS_W-1:0] status_in;
   logic                          grant_ff;
   logic                          grant_in;
   logic [fbot_pkg::SLOT_W-1:0]   gslot_ff;
   logic [fbot_pkg::SLOT_W-1:0]   gslot_in;

   logic                    accept;
   logic                    in_range;
   logic [AW-1:0]           slot_idx;
   logic                    found;
   logic [AW-1:0]           first_idx;
   fbot_pkg::ready_cmd_type ready_cmd;
   logic [AW-1:0]           ready_idx;
   logic                    mem_wr;
   logic                    mem_rd;
   logic [fbot_pkg::TIME_W-1:0] mem_rd_data;

   assign accept   = start && !busy_ff;
   assign in_range = req_buffer_slot < fbot_pkg::SLOT_W'(NUM_BUFFERS);
   assign slot_idx = req_buffer_slot[AW-1:0];

   always_comb begin
      status_in     = fbot_pkg::ST_OK;
      grant_in      = 1'b0;
      streaming_in  = streaming_ff;
      ready_cmd.set = 1'b0;
      ready_cmd.clr = 1'b0;
      ready_idx     = slot_idx;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      unique case (req_operation)
         fbot_pkg::OP_FRAME_DONE: begin
            if (!in_range) begin
               status_in = fbot_pkg::ST_BAD_INDEX;
            end else begin
               ready_cmd.set = accept;
               mem_wr        = accept;
            end
         end
         fbot_pkg::OP_DEQUEUE: begin
            ready_idx = first_idx;
            if (!streaming_ff) begin
               status_in = fbot_pkg::ST_NOT_STREAMING;
            end else if (!found) begin
               status_in = fbot_pkg::ST_NONE_READY;
            end else begin
               grant_in      = 1'b1;
               ready_cmd.clr = accept;
               mem_rd        = accept;
            end
         end
         fbot_pkg::OP_RELEASE: begin
            if (!in_range) begin
               status_in = fbot_pkg::ST_BAD_INDEX;
            end else begin
               ready_cmd.clr = accept;
            end
         end
         fbot_pkg::OP_STREAM_ON: begin
            if (streaming_ff) begin
               status_in = fbot_pkg::ST_UNCHANGED;
            end else begin
               streaming_in = 1'b1;
            end
         end
         fbot_pkg::OP_STREAM_OFF: begin
            if (!streaming_ff) begin
               status_in = fbot_pkg::ST_UNCHANGED;
            end else begin
               streaming_in = 1'b0;
            end
         end
         default: begin
            status_in = fbot_pkg::ST_OK;
         end
      endcase
      gslot_in = grant_in ? fbot_pkg::SLOT_W'(first_idx) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         streaming_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
         if (accept) begin
            streaming_ff <= streaming_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         gslot_ff  <= gslot_in;
      end
   end

   fbot_ready_table #(
      .DEPTH (NUM_BUFFERS),
      .AW    (AW)
   ) u_ready_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ready_cmd),
      .idx       (ready_idx),
      .found     (found),
      .first_idx (first_idx)
   );

   fbot_time_ram #(
      .DEPTH (NUM_BUFFERS),
      .AW    (AW)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (slot_idx),
      .wr_data (req_capture_time),
      .rd_en   (mem_rd),
      .rd_addr (first_idx),
      .rd_data (mem_rd_data)
   );

   assign busy             = busy_ff;
   assign rsp_strobe       = busy_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_slot = gslot_ff;
   assign rsp_granted_time = grant_ff ? mem_rd_data : '0;

endmodule

`default_nettype wire

// ----- rtl/fbot_checker.sv -----
`default_nettype none

module fbot_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_strobe,
   input wire logic [fbot_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [fbot_pkg::SLOT_W-1:0]   rsp_granted_slot,
   input wire logic [fbot_pkg::TIME_W-1:0]   rsp_granted_time
);

   // Every accepted command yields its result in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted command gave no result beat");

   // A result beat never appears without a command behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result beat without an accepted command");

   // A failed command never carries a non-zero grant.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != fbot_pkg::ST_OK)
         |-> (rsp_granted_slot == '0 && rsp_granted_time == '0))
      else $error("grant fields set on a failed command");

   // Status stays within the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == fbot_pkg::ST_OK
                      || rsp_status == fbot_pkg::ST_BAD_INDEX
                      || rsp_status == fbot_pkg::ST_NOT_STREAMING
                      || rsp_status == fbot_pkg::ST_NONE_READY
                      || rsp_status == fbot_pkg::ST_UNCHANGED))
      else $error("undefined status code on a result beat");

endmodule

bind frame_buffer_ownership_table fbot_checker u_fbot_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_granted_slot (rsp_granted_slot),
   .rsp_granted_time (rsp_granted_time)
);

`default_nettype wire

// ----- sim/tb_frame_buffer_ownership_table.sv -----
`default_nettype none

module tb_frame_buffer_ownership_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BUFFERS    = 8;
   localparam int RANDOM_PER_RUN = 384;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int OP_W           = fbot_pkg::OP_W;
   localparam int SLOT_W         = fbot_pkg::SLOT_W;
   localparam int TIME_W         = fbot_pkg::TIME_W;
   localparam int STATUS_W       = fbot_pkg::STATUS_W;
   localparam logic [OP_W-1:0] OP_LAST_CODE = {OP_W{1'b1}};

   typedef enum logic [1:0] {
      OWNED_BY_PRODUCER = 2'd0,
      QUEUED_READY      = 2'd1,
      HELD_BY_CONSUMER  = 2'd2
   } owner_type;

   typedef struct {
      logic [OP_W-1:0]   operation;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] stamp;
      int unsigned       idle_pct;
   } command_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   granted_slot;
      logic [TIME_W-1:0]   granted_stamp;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [OP_W-1:0]     req_operation = '0;
   logic [SLOT_W-1:0]   req_buffer_slot = '0;
   logic [TIME_W-1:0]   req_capture_time = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_granted_slot;
   logic [TIME_W-1:0]   rsp_granted_time;

   command_type pending_commands[$];
   outcome_type awaited_outcomes[$];
   owner_type   buffer_owner[NUM_BUFFERS];
   logic [TIME_W-1:0] buffer_stamp[NUM_BUFFERS];
   logic        stream_active;
   int          fail_count = 0;
   int          quiet_cycles = 0;

   wire command_taken = start && (busy === 1'b0);

   frame_buffer_ownership_table #(
      .NUM_BUFFERS(NUM_BUFFERS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_buffer_slot  (req_buffer_slot),
      .req_capture_time (req_capture_time),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_granted_time (rsp_granted_time)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic outcome_type apply_command(command_type c);
      outcome_type r;
      bit          found;
      r = '{status: fbot_pkg::ST_OK, granted_slot: '0, granted_stamp: '0};
      found = 1'b0;
      case (c.operation)
         fbot_pkg::OP_FRAME_DONE: begin
            if (c.slot >= NUM_BUFFERS) begin
               r.status = fbot_pkg::ST_BAD_INDEX;
            end else begin
               buffer_stamp[c.slot] = c.stamp;
               buffer_owner[c.slot] = QUEUED_READY;
            end
         end
         fbot_pkg::OP_DEQUEUE: begin
            if (!stream_active) begin
               r.status = fbot_pkg::ST_NOT_STREAMING;
            end else begin
               r.status = fbot_pkg::ST_NONE_READY;
               for (int i = 0; i < NUM_BUFFERS; i++) begin
                  if (!found && buffer_owner[i] == QUEUED_READY) begin
                     found = 1'b1;
                     buffer_owner[i] = HELD_BY_CONSUMER;
                     r.granted_slot = SLOT_W'(i);
                     r.granted_stamp = buffer_stamp[i];
                     r.status = fbot_pkg::ST_OK;
                  end
               end
            end
         end
         fbot_pkg::OP_RELEASE: begin
            if (c.slot >= NUM_BUFFERS) r.status = fbot_pkg::ST_BAD_INDEX;
            else buffer_owner[c.slot] = OWNED_BY_PRODUCER;
         end
         fbot_pkg::OP_STREAM_ON: begin
            if (stream_active) r.status = fbot_pkg::ST_UNCHANGED;
            else stream_active = 1'b1;
         end
         fbot_pkg::OP_STREAM_OFF: begin
            if (!stream_active) r.status = fbot_pkg::ST_UNCHANGED;
            else stream_active = 1'b0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic void push_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                        logic [TIME_W-1:0] stamp, int unsigned idle_pct);
      command_type c;
      c = '{operation: op, slot: slot, stamp: stamp, idle_pct: idle_pct};
      pending_commands.push_back(c);
   endfunction

   function automatic logic [TIME_W-1:0] random_stamp();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SLOT_W-1:0] good_slot();
      return SLOT_W'($urandom_range(0, NUM_BUFFERS - 1));
   endfunction

   function automatic logic [SLOT_W-1:0] bad_slot();
      return SLOT_W'($urandom_range(NUM_BUFFERS, (1 << SLOT_W) - 1));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (command_taken) begin
            awaited_outcomes.push_back(apply_command(pending_commands[0]));
            void'(pending_commands.pop_front());
         end
         if (!start || command_taken) begin
            if (pending_commands.size() != 0 &&
                $urandom_range(0, 99) >= pending_commands[0].idle_pct) begin
               start            <= 1'b1;
               req_operation    <= pending_commands[0].operation;
               req_buffer_slot  <= pending_commands[0].slot;
               req_capture_time <= pending_commands[0].stamp;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      outcome_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_outcomes.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("%0t: result beat with nothing outstanding: status %0d slot %0d time %h",
                        $realtime, rsp_status, rsp_granted_slot, rsp_granted_time);
            fail_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_granted_slot !== want.granted_slot ||
                rsp_granted_time !== want.granted_stamp) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: mismatch: expected status %0d slot %0d time %h, got %0d %0d %h",
                           $realtime, want.status, want.granted_slot, want.granted_stamp,
                           rsp_status, rsp_granted_slot, rsp_granted_time);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || command_taken || rsp_strobe === 1'b1 ||
          (pending_commands.size() == 0 && awaited_outcomes.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** frame_buffer_ownership_table: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned idle_by_phase[3];
      int unsigned pick;
      idle_by_phase = '{0, 63, 24};
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         buffer_owner[i] = OWNED_BY_PRODUCER;
         buffer_stamp[i] = '0;
      end
      stream_active = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: every operation, the field extremes and each rejection path.
      push_command(fbot_pkg::OP_STREAM_OFF, 8'hFF, '1, 0);
      push_command(fbot_pkg::OP_DEQUEUE, 8'h00, '0, 0);
      push_command(fbot_pkg::OP_FRAME_DONE, 8'd0, '0, 0);
      push_command(fbot_pkg::OP_FRAME_DONE, SLOT_W'(NUM_BUFFERS - 1), '1, 0);
      push_command(fbot_pkg::OP_FRAME_DONE, SLOT_W'(NUM_BUFFERS), random_stamp(), 0);
      push_command(fbot_pkg::OP_FRAME_DONE, 8'hFF, '1, 0);
      push_command(fbot_pkg::OP_RELEASE, 8'hFF, '0, 0);
      push_command(fbot_pkg::OP_RELEASE, SLOT_W'(NUM_BUFFERS), '0, 0);
      push_command(fbot_pkg::OP_STREAM_ON, 8'h00, '0, 0);
      push_command(fbot_pkg::OP_STREAM_ON, 8'hFF, '1, 0);
      push_command(fbot_pkg::OP_DEQUEUE, 8'hFF, '1, 0);
      push_command(fbot_pkg::OP_DEQUEUE, 8'h00, '0, 0);
      push_command(fbot_pkg::OP_DEQUEUE, 8'hA5, random_stamp(), 0);
      push_command(fbot_pkg::OP_FRAME_DONE, 8'd0, 64'h0123_4567_89AB_CDEF, 0);
      push_command(fbot_pkg::OP_RELEASE, SLOT_W'(NUM_BUFFERS - 1), '0, 0);
      push_command(fbot_pkg::OP_RELEASE, 8'd3, '0, 0);
      push_command(fbot_pkg::OP_FRAME_DONE, 8'd5, random_stamp(), 0);
      push_command(fbot_pkg::OP_RELEASE, 8'd5, random_stamp(), 0);
      push_command(fbot_pkg::OP_DEQUEUE, 8'h00, '0, 0);
      for (int op = fbot_pkg::OP_STREAM_OFF + 1; op <= OP_LAST_CODE; op++)
         push_command(OP_W'(op), SLOT_W'($urandom_range(0, 255)), random_stamp(), 0);
      push_command(fbot_pkg::OP_STREAM_OFF, 8'h00, '0, 0);
      push_command(fbot_pkg::OP_FRAME_DONE, 8'd2, random_stamp(), 0);
      push_command(fbot_pkg::OP_DEQUEUE, 8'h00, '0, 0);
      push_command(fbot_pkg::OP_STREAM_ON, 8'h00, '0, 0);
      push_command(fbot_pkg::OP_DEQUEUE, 8'h00, '0, 0);

      // Random beats, mostly well-formed traffic while streaming.
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < RANDOM_PER_RUN; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               push_command(fbot_pkg::OP_FRAME_DONE, good_slot(), random_stamp(),
                            idle_by_phase[phase]);
            else if (pick < 60)
               push_command(fbot_pkg::OP_DEQUEUE, SLOT_W'($urandom_range(0, 255)),
                            random_stamp(), idle_by_phase[phase]);
            else if (pick < 80)
               push_command(fbot_pkg::OP_RELEASE, good_slot(), random_stamp(),
                            idle_by_phase[phase]);
            else if (pick < 86)
               push_command(fbot_pkg::OP_STREAM_ON, SLOT_W'($urandom_range(0, 255)),
                            random_stamp(), idle_by_phase[phase]);
            else if (pick < 90)
               push_command(fbot_pkg::OP_STREAM_OFF, SLOT_W'($urandom_range(0, 255)),
                            random_stamp(), idle_by_phase[phase]);
            else if (pick < 94)
               push_command(fbot_pkg::OP_FRAME_DONE, bad_slot(), random_stamp(),
                            idle_by_phase[phase]);
            else if (pick < 97)
               push_command(fbot_pkg::OP_RELEASE, bad_slot(), random_stamp(),
                            idle_by_phase[phase]);
            else
               push_command(OP_W'($urandom_range(fbot_pkg::OP_STREAM_OFF + 1, OP_LAST_CODE)),
                            SLOT_W'($urandom_range(0, 255)), random_stamp(),
                            idle_by_phase[phase]);
         end
      end

      wait (pending_commands.size() == 0 && awaited_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && awaited_outcomes.size() == 0)
         $display("** frame_buffer_ownership_table: PASSED **");
      else
         $display("** frame_buffer_ownership_table: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ----- frame_buffer_ownership_table.f -----
rtl/fbot_pkg.sv
rtl/fbot_time_ram.sv
rtl/fbot_ready_table.sv
rtl/frame_buffer_ownership_table.sv
rtl/fbot_checker.sv
sim/tb_frame_buffer_ownership_table.sv
